FILE: hdl/wpcm_pkg.sv
// Shared types, constants and helpers for the world-to-pixel cross marker.
package wpcm_pkg;

  localparam int CROSS_ARM = 5;
  localparam int MAX_DIM   = 4096;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int DIM_W     = 13;
  localparam int POS_W     = 32;
  localparam int COLOR_W   = 8;
  localparam int Q_DEPTH   = 4;
  localparam int QA_W      = $clog2(Q_DEPTH);
  localparam int QC_W      = $clog2(Q_DEPTH + 1);

  localparam logic OP_BODY  = 1'b0;
  localparam logic OP_CROSS = 1'b1;

  localparam logic [COLOR_W-1:0] WHITE = COLOR_W'(255);

  typedef enum logic [2:0] {
    REG_BOX_X_MIN  = 3'd0,
    REG_BOX_X_MAX  = 3'd1,
    REG_BOX_Y_MIN  = 3'd2,
    REG_BOX_Y_MAX  = 3'd3,
    REG_SCALE_X    = 3'd4,
    REG_SCALE_Y    = 3'd5,
    REG_IMG_WIDTH  = 3'd6,
    REG_IMG_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] box_x_min;
    logic signed [POS_W-1:0] box_x_max;
    logic signed [POS_W-1:0] box_y_min;
    logic signed [POS_W-1:0] box_y_max;
    logic [POS_W-1:0]        scale_x;
    logic [POS_W-1:0]        scale_y;
    logic [DIM_W-1:0]        image_width;
    logic [DIM_W-1:0]        image_height;
  } cfg_t;

  // Decoded item: center pixel plus precomputed arm extents on the image.
  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] hlo;
    logic [COORD_W-1:0] hhi;
    logic [COORD_W-1:0] vlo;
    logic [COORD_W-1:0] vhi;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } entry_t;

  // Last valid coordinate for a configured dimension (0 acts as 1, capped at MAX_DIM).
  function automatic logic [COORD_W-1:0] dim_last(input logic [DIM_W-1:0] d);
    logic [COORD_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = COORD_W'(MAX_DIM - 1);
    end else begin
      r = COORD_W'(d - DIM_W'(1));
    end
    return r;
  endfunction

endpackage

FILE: hdl/wpcm_front.sv
// Front end: box test, Q16.16 scaling multiply, clamp and arm extents.
module wpcm_front
  import wpcm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       op,
  input  logic signed [POS_W-1:0]    pos_x,
  input  logic signed [POS_W-1:0]    pos_y,
  input  logic [COLOR_W-1:0]         in_red,
  input  logic [COLOR_W-1:0]         in_green,
  input  logic [COLOR_W-1:0]         in_blue,
  input  cfg_t                       cfg,
  output logic                       enq,
  output entry_t                     entry,
  output logic [1:0]                 inflight
);

  logic               in_box;
  logic               s1_v;
  logic               s1_op;
  logic [POS_W-1:0]   s1_dx;
  logic [POS_W-1:0]   s1_dy;
  logic [COLOR_W-1:0] s1_r, s1_g, s1_b;
  logic               s2_v;
  logic               s2_op;
  logic [POS_W-1:0]   s2_hx;
  logic [POS_W-1:0]   s2_hy;
  logic [COLOR_W-1:0] s2_r, s2_g, s2_b;
  logic [2*POS_W-1:0] prod_x;
  logic [2*POS_W-1:0] prod_y;
  logic [COORD_W-1:0] wl, hl;
  logic [COORD_W-1:0] cx, cy;
  logic [COORD_W:0]   xp, yp;
  logic [COORD_W-1:0] arm;

  assign in_box = (pos_x >= cfg.box_x_min) && (pos_x <= cfg.box_x_max) &&
                  (pos_y >= cfg.box_y_min) && (pos_y <= cfg.box_y_max);

  assign prod_x = s1_dx * cfg.scale_x;
  assign prod_y = s1_dy * cfg.scale_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= accept && in_box;
      s2_v <= s1_v;
    end
    // difference fits unsigned 32 bits once inside the box
    s1_op <= op;
    s1_dx <= POS_W'(pos_x - cfg.box_x_min);
    s1_dy <= POS_W'(pos_y - cfg.box_y_min);
    s1_r  <= in_red;
    s1_g  <= in_green;
    s1_b  <= in_blue;
    s2_op <= s1_op;
    s2_hx <= prod_x[2*POS_W-1:POS_W];
    s2_hy <= prod_y[2*POS_W-1:POS_W];
    s2_r  <= s1_r;
    s2_g  <= s1_g;
    s2_b  <= s1_b;
  end

  // clamp to the image and work out the clipped arm ends
  always_comb begin
    wl  = dim_last(cfg.image_width);
    hl  = dim_last(cfg.image_height);
    arm = COORD_W'(CROSS_ARM);
    cx  = (s2_hx > POS_W'(wl)) ? wl : s2_hx[COORD_W-1:0];
    cy  = (s2_hy > POS_W'(hl)) ? hl : s2_hy[COORD_W-1:0];
    xp  = {1'b0, cx} + {1'b0, arm};
    yp  = {1'b0, cy} + {1'b0, arm};
    entry.op    = s2_op;
    entry.x     = cx;
    entry.y     = cy;
    entry.hlo   = (cx >= arm) ? cx - arm : '0;
    entry.vlo   = (cy >= arm) ? cy - arm : '0;
    entry.hhi   = (xp > {1'b0, wl}) ? wl : xp[COORD_W-1:0];
    entry.vhi   = (yp > {1'b0, hl}) ? hl : yp[COORD_W-1:0];
    entry.red   = s2_r;
    entry.green = s2_g;
    entry.blue  = s2_b;
  end

  assign enq      = s2_v;
  assign inflight = {1'b0, s1_v} + {1'b0, s2_v};

endmodule

FILE: hdl/wpcm_queue.sv
// Small register queue of decoded items between front and back.
module wpcm_queue
  import wpcm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            enq,
  input  entry_t          enq_entry,
  input  logic            deq,
  output logic            head_valid,
  output entry_t          head,
  output logic [QC_W-1:0] count
);

  entry_t          slots [Q_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      if (enq && !deq) begin
        count <= count + QC_W'(1);
      end else if (deq && !enq) begin
        count <= count - QC_W'(1);
      end
    end
    if (enq) begin
      slots[wr_ptr] <= enq_entry;
    end
  end

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

endmodule

FILE: hdl/wpcm_back.sv
// Back end: pixel sequencer; body items and cross arms go to the output register.
module wpcm_back
  import wpcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  entry_t             head,
  output logic               deq,
  input  logic               pop,
  output logic               out_valid,
  output logic [COORD_W-1:0] pix_x,
  output logic [COORD_W-1:0] pix_y,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue,
  output logic               last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HORZ,
    S_VERT
  } state_t;

  state_t             state;
  entry_t             ent;
  logic [COORD_W-1:0] cur;
  logic               advance;

  assign advance = !out_valid || pop;
  assign deq     = advance && (state == S_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else if (advance) begin
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            out_valid <= 1'b1;
            ent       <= head;
            pix_y     <= head.y;
            if (head.op == OP_BODY) begin
              pix_x     <= head.x;
              out_red   <= WHITE;
              out_green <= WHITE;
              out_blue  <= WHITE;
              last      <= 1'b1;
            end else begin
              pix_x     <= head.hlo;
              out_red   <= head.red;
              out_green <= head.green;
              out_blue  <= head.blue;
              last      <= 1'b0;
              if (head.hlo == head.hhi) begin
                state <= S_VERT;
                cur   <= head.vlo;
              end else begin
                state <= S_HORZ;
                cur   <= head.hlo + COORD_W'(1);
              end
            end
          end else begin
            out_valid <= 1'b0;
          end
        end
        S_HORZ: begin
          out_valid <= 1'b1;
          pix_x     <= cur;
          pix_y     <= ent.y;
          last      <= 1'b0;
          if (cur == ent.hhi) begin
            state <= S_VERT;
            cur   <= ent.vlo;
          end else begin
            cur <= cur + COORD_W'(1);
          end
        end
        S_VERT: begin
          out_valid <= 1'b1;
          pix_x     <= ent.x;
          pix_y     <= cur;
          last      <= (cur == ent.vhi);
          if (cur == ent.vhi) begin
            state <= S_IDLE;
          end else begin
            cur <= cur + COORD_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/world_to_pixel_cross_marker_core.sv
// Top level of the world-to-pixel cross marker: config registers, front, queue, back.
// An accepted item passes front registers s1 and s2 and a queue slot before its first
//   pixel reaches the output register. A body item gives one pixel, a cross 2 to 22,
//   one pixel per cycle while the receiver pops; off-box items are dropped on entry.
// Reset (rst, synchronous, active high) empties pipeline, queue and sequencer and
//   loads every config register with its documented reset value.
module world_to_pixel_cross_marker_core
  import wpcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // config write port
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [POS_W-1:0]        cfg_data,
  // input item side
  input  logic                    push,
  output logic                    full,
  input  logic                    op,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [COLOR_W-1:0]      in_red,
  input  logic [COLOR_W-1:0]      in_green,
  input  logic [COLOR_W-1:0]      in_blue,
  // result side
  output logic                    empty,
  input  logic                    pop,
  output logic [COORD_W-1:0]      pix_x,
  output logic [COORD_W-1:0]      pix_y,
  output logic [COLOR_W-1:0]      out_red,
  output logic [COLOR_W-1:0]      out_green,
  output logic [COLOR_W-1:0]      out_blue,
  output logic                    last
);

  cfg_t            cfg;
  reg_idx_t        widx;
  logic            accept;
  logic            enq;
  entry_t          enq_entry;
  logic [1:0]      inflight;
  logic            deq;
  logic            head_valid;
  entry_t          head;
  logic [QC_W-1:0] q_count;
  logic            out_valid;

  // Config registers. A write takes effect at once; it is meant for idle periods.
  assign widx = reg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x_min    <= POS_W'(0);
      cfg.box_x_max    <= POS_W'(65536);
      cfg.box_y_min    <= POS_W'(0);
      cfg.box_y_max    <= POS_W'(65536);
      cfg.scale_x      <= POS_W'(65536);
      cfg.scale_y      <= POS_W'(65536);
      cfg.image_width  <= DIM_W'(1024);
      cfg.image_height <= DIM_W'(1024);
    end else if (cfg_we) begin
      unique case (widx)
        REG_BOX_X_MIN:  cfg.box_x_min    <= cfg_data;
        REG_BOX_X_MAX:  cfg.box_x_max    <= cfg_data;
        REG_BOX_Y_MIN:  cfg.box_y_min    <= cfg_data;
        REG_BOX_Y_MAX:  cfg.box_y_max    <= cfg_data;
        REG_SCALE_X:    cfg.scale_x      <= cfg_data;
        REG_SCALE_Y:    cfg.scale_y      <= cfg_data;
        REG_IMG_WIDTH:  cfg.image_width  <= cfg_data[DIM_W-1:0];
        REG_IMG_HEIGHT: cfg.image_height <= cfg_data[DIM_W-1:0];
      endcase
    end
  end

  // Credit check: every item in the front pipeline has a queue slot reserved,
  // so the front never has to stall mid-flight.
  assign full   = ({1'b0, q_count} + 4'(inflight)) >= 4'(Q_DEPTH);
  assign accept = push && !full;

  wpcm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (op),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .cfg      (cfg),
    .enq      (enq),
    .entry    (enq_entry),
    .inflight (inflight)
  );

  wpcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .enq        (enq),
    .enq_entry  (enq_entry),
    .deq        (deq),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  // Back end owns the output register; it refills it in the same cycle a pixel is popped.
  wpcm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .deq        (deq),
    .pop        (pop),
    .out_valid  (out_valid),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .last       (last)
  );

  assign empty = !out_valid;

endmodule

FILE: hdl/wpcm_checker.sv
// Port-level checks for the cross marker top level, bound into it.
module wpcm_checker
  import wpcm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [COORD_W-1:0] pix_x,
  input logic [COORD_W-1:0] pix_y,
  input logic [COLOR_W-1:0] out_red,
  input logic [COLOR_W-1:0] out_green,
  input logic [COLOR_W-1:0] out_blue,
  input logic               last
);

  // reset leaves both sides open and nothing pending
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("reset did not clear the block");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pix_x) && $stable(pix_y) && $stable(last)))
    else $error("result changed while stalled");

  // inside a cross the next pixel follows at once
  a_cross_cont: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> !empty)
    else $error("gap inside a cross");

  // one cross keeps one color
  a_cross_color: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> (out_red == $past(out_red) &&
                                  out_green == $past(out_green) &&
                                  out_blue == $past(out_blue)))
    else $error("color changed inside a cross");

endmodule

bind world_to_pixel_cross_marker_core wpcm_checker u_wpcm_checker (.*);

FILE: tb/world_to_pixel_cross_marker_core_tb.sv
// Self-checking testbench for the world-to-pixel cross marker core.
module world_to_pixel_cross_marker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wpcm_pkg::*;

  localparam int ONE        = 65536;     // 1.0 in Q16.16
  localparam int CYCLE_CAP  = 400000;    // run is far shorter even on worst-case stalls
  localparam int SETTLE     = 8;         // longer than the front and queue path, covers items that map off-box
  localparam int RAND_PHASE = 6;
  localparam int PHASE_LEN  = 52;

  // One accepted item and one pixel as seen on the ports.
  typedef struct {
    logic                    op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [COLOR_W-1:0]      red;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      blue;
  } item_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } pixel_t;

  // Keeps a shadow of the registers, turns each accepted item into the pixels it
  // must produce, and matches the pixels that come out in order.
  class marker_scoreboard;
    cfg_t   regs;
    pixel_t pending[$];
    int     errors;

    function new();
      regs.box_x_min    = 0;
      regs.box_x_max    = ONE;
      regs.box_y_min    = 0;
      regs.box_y_max    = ONE;
      regs.scale_x      = ONE;
      regs.scale_y      = ONE;
      regs.image_width  = DIM_W'(1024);
      regs.image_height = DIM_W'(1024);
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [POS_W-1:0] v);
      case (idx)
        REG_BOX_X_MIN:  regs.box_x_min    = v;
        REG_BOX_X_MAX:  regs.box_x_max    = v;
        REG_BOX_Y_MIN:  regs.box_y_min    = v;
        REG_BOX_Y_MAX:  regs.box_y_max    = v;
        REG_SCALE_X:    regs.scale_x      = v;
        REG_SCALE_Y:    regs.scale_y      = v;
        REG_IMG_WIDTH:  regs.image_width  = v[DIM_W-1:0];
        REG_IMG_HEIGHT: regs.image_height = v[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // 0 reads as 1, anything above MAX_DIM as MAX_DIM
    function logic [DIM_W-1:0] fit_dim(logic [DIM_W-1:0] d);
      if (d == '0) return DIM_W'(1);
      if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
      return d;
    endfunction

    // floor((pos - lo) * scale) with the Q32.32 fraction dropped, saturated at dim-1
    function logic [COORD_W-1:0] to_pixel(logic signed [POS_W-1:0] pos,
                                          logic signed [POS_W-1:0] lo,
                                          logic [POS_W-1:0] scale,
                                          logic [DIM_W-1:0] dim);
      logic [63:0] diff;
      logic [63:0] prod;
      diff = 64'($signed(pos)) - 64'($signed(lo));
      prod = (diff * {32'b0, scale}) >> 32;
      if (prod > 64'(dim - 1)) prod = 64'(dim - 1);
      return prod[COORD_W-1:0];
    endfunction

    function void note_item(item_t it);
      logic [DIM_W-1:0]   w;
      logic [DIM_W-1:0]   h;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      pixel_t             arms[$];
      pixel_t             p;
      int                 c;
      w = fit_dim(regs.image_width);
      h = fit_dim(regs.image_height);
      // inclusive box; an inverted box swallows everything
      if ($signed(it.pos_x) < $signed(regs.box_x_min) ||
          $signed(it.pos_x) > $signed(regs.box_x_max) ||
          $signed(it.pos_y) < $signed(regs.box_y_min) ||
          $signed(it.pos_y) > $signed(regs.box_y_max)) return;
      cx = to_pixel(it.pos_x, regs.box_x_min, regs.scale_x, w);
      cy = to_pixel(it.pos_y, regs.box_y_min, regs.scale_y, h);
      if (it.op == OP_BODY) begin
        pending.push_back('{cx, cy, WHITE, WHITE, WHITE, 1'b1});
        return;
      end
      // horizontal arm first, then vertical; center shows up in both
      for (int d = -CROSS_ARM; d <= CROSS_ARM; d++) begin
        c = int'(cx) + d;
        if (c >= 0 && c < int'(w)) arms.push_back('{COORD_W'(c), cy, it.red, it.green, it.blue, 1'b0});
      end
      for (int d = -CROSS_ARM; d <= CROSS_ARM; d++) begin
        c = int'(cy) + d;
        if (c >= 0 && c < int'(h)) arms.push_back('{cx, COORD_W'(c), it.red, it.green, it.blue, 1'b0});
      end
      foreach (arms[i]) begin
        p = arms[i];
        p.last = (i == arms.size() - 1);
        pending.push_back(p);
      end
    endfunction

    function void field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        $error("pixel with nothing pending: x=%0d y=%0d", got.x, got.y);
        errors++;
        return;
      end
      want = pending.pop_front();
      field("pix_x", 32'(want.x), 32'(got.x));
      field("pix_y", 32'(want.y), 32'(got.y));
      field("out_red", 32'(want.red), 32'(got.red));
      field("out_green", 32'(want.green), 32'(got.green));
      field("out_blue", 32'(want.blue), 32'(got.blue));
      field("last", 32'(want.last), 32'(got.last));
    endfunction

    function int waiting();
      return pending.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [2:0]              cfg_index = '0;
  logic [POS_W-1:0]        cfg_data = '0;
  logic                    push = 1'b0;
  logic                    full;
  logic                    op = 1'b0;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic [COLOR_W-1:0]      in_red = '0;
  logic [COLOR_W-1:0]      in_green = '0;
  logic [COLOR_W-1:0]      in_blue = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [COORD_W-1:0]      pix_x;
  logic [COORD_W-1:0]      pix_y;
  logic [COLOR_W-1:0]      out_red;
  logic [COLOR_W-1:0]      out_green;
  logic [COLOR_W-1:0]      out_blue;
  logic                    last;

  marker_scoreboard sb = new();
  int               cycles = 0;
  int               burst_left = 0;
  int               rx_mode = 0;
  int               rx_left = 0;

  world_to_pixel_cross_marker_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .op(op), .pos_x(pos_x), .pos_y(pos_y),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .empty(empty), .pop(pop), .pix_x(pix_x), .pix_y(pix_y),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung pipeline or a lost pixel ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $error("timeout with %0d pixels still pending", sb.waiting());
      $display("world_to_pixel_cross_marker_core_tb: done, errors");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge, before any NBA of that step lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_item('{op, pos_x, pos_y, in_red, in_green, in_blue});
      if (pop && !empty) sb.check_pixel('{pix_x, pix_y, out_red, out_green, out_blue, last});
    end
  end

  // Receiver back-pressure. Modes change at random: always ready, coin flip, mostly
  // stalled, and a fixed 5-of-8 pattern, so stalls hit every arm position.
  always @(posedge clk) begin
    if (rst) begin
      pop     <= 1'b0;
      rx_mode <= 0;
      rx_left <= 100;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_left <= $urandom_range(64, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        2:       pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ((cycles % 8) >= 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: holds the item until accepted. Bursts run back to back; at the end
  // of a burst push drops for a random gap. Some bursts are long so the core
  // also sees stretches with no idle at all on the input.
  task automatic send(item_t it);
    push     <= 1'b1;
    op       <= it.op;
    pos_x    <= it.pos_x;
    pos_y    <= it.pos_y;
    in_red   <= it.red;
    in_green <= it.green;
    in_blue  <= it.blue;
    @(posedge clk);
    while (full) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Wait for every predicted pixel, then let off-box items flush through.
  task automatic drain();
    if (push) push <= 1'b0;
    do @(posedge clk); while (sb.waiting() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [POS_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Core is idle whenever this runs.
  task automatic load_cfg(cfg_t c);
    write_reg(REG_BOX_X_MIN, c.box_x_min);
    write_reg(REG_BOX_X_MAX, c.box_x_max);
    write_reg(REG_BOX_Y_MIN, c.box_y_min);
    write_reg(REG_BOX_Y_MAX, c.box_y_max);
    write_reg(REG_SCALE_X, c.scale_x);
    write_reg(REG_SCALE_Y, c.scale_y);
    write_reg(REG_IMG_WIDTH, POS_W'(c.image_width));
    write_reg(REG_IMG_HEIGHT, POS_W'(c.image_height));
    cfg_we <= 1'b0;
  endtask

  function automatic item_t mk(logic o, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                               logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                               logic [COLOR_W-1:0] b);
    return '{o, x, y, r, g, b};
  endfunction

  // Mostly inside the box (including its edges), sometimes anywhere.
  function automatic logic signed [POS_W-1:0] pick_coord(logic signed [POS_W-1:0] lo,
                                                        logic signed [POS_W-1:0] hi);
    logic signed [63:0] span;
    logic [63:0]        off;
    span = 64'(hi) - 64'(lo);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return lo;
      2: return hi;
      default: begin
        if (span < 0) return $urandom;
        off = {$urandom, $urandom} % 64'(span + 1);
        return lo + off[POS_W-1:0];
      end
    endcase
  endfunction

  function automatic item_t rand_item();
    return mk(1'($urandom_range(0, 1)),
              pick_coord(sb.regs.box_x_min, sb.regs.box_x_max),
              pick_coord(sb.regs.box_y_min, sb.regs.box_y_max),
              COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
  endfunction

  // Includes the zero and oversize codes now and then.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
      2:       return DIM_W'($urandom_range(1, 16));
      default: return DIM_W'($urandom_range(1, MAX_DIM));
    endcase
  endfunction

  // Box either anywhere in the 32-bit range or a narrow window; scale is the
  // matching dim/span, sometimes pushed high so the far edge saturates, or random.
  function automatic void rand_axis(output logic signed [POS_W-1:0] lo,
                                    output logic signed [POS_W-1:0] hi,
                                    output logic [POS_W-1:0] scale,
                                    input logic [DIM_W-1:0] dim);
    logic signed [POS_W-1:0] t;
    logic [63:0]             span;
    logic [63:0]             s;
    if ($urandom_range(0, 1)) begin
      lo = $urandom;
      hi = $urandom;
      if (hi < lo) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    end else begin
      lo = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      hi = lo + $urandom_range(1, 1 << 23);
    end
    span = 64'(hi) - 64'(lo);
    s = (span == 0) ? 64'($urandom) : (64'(dim) << 32) / span;
    case ($urandom_range(0, 3))
      0: s = s + s / 8;
      1: s = 64'($urandom);
      default: ;
    endcase
    scale = (s > 64'hFFFF_FFFF) ? '1 : s[POS_W-1:0];
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.image_width  = pick_dim();
    c.image_height = pick_dim();
    rand_axis(c.box_x_min, c.box_x_max, c.scale_x, c.image_width);
    rand_axis(c.box_y_min, c.box_y_max, c.scale_y, c.image_height);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  initial begin
    cfg_t c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset config: unit box, scale 1.0, 1024x1024. Crosses at the origin
    // clip their negative arms; points just off the box give nothing.
    send(mk(OP_BODY, 0, 0, 8'h00, 8'h00, 8'h00));
    send(mk(OP_CROSS, 0, 0, 8'hFF, 8'h00, 8'hFF));
    send(mk(OP_CROSS, ONE, ONE, 8'h00, 8'hFF, 8'h00));
    send(mk(OP_BODY, ONE, ONE / 2, 8'h12, 8'h34, 8'h56));
    send(mk(OP_BODY, -1, 0, 8'hFF, 8'hFF, 8'hFF));
    send(mk(OP_CROSS, 0, ONE + 1, 8'hFF, 8'hFF, 8'hFF));
    drain();

    // Full-range box, max scale on x (saturates), zero scale on y,
    // oversized width and zero height.
    c.box_x_min    = 32'sh8000_0000;
    c.box_x_max    = 32'sh7FFF_FFFF;
    c.box_y_min    = 32'sh8000_0000;
    c.box_y_max    = 32'sh7FFF_FFFF;
    c.scale_x      = 32'hFFFF_FFFF;
    c.scale_y      = '0;
    c.image_width  = DIM_W'(8191);
    c.image_height = '0;
    load_cfg(c);
    send(mk(OP_BODY, 32'sh8000_0000, 32'sh8000_0000, 8'h00, 8'h00, 8'h00));
    send(mk(OP_CROSS, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'hA5, 8'h5A, 8'hC3));
    send(mk(OP_CROSS, 0, 0, 8'h3C, 8'hC3, 8'h0F));
    send(mk(OP_BODY, 32'sh7FFF_FFFF, 32'sh8000_0000, 8'hFF, 8'hFF, 8'hFF));
    drain();

    // 4096x4096 with x = floor(pos): full 22-pixel cross mid-image, the far
    // edge clamped to 4095, and arms clipped near both borders.
    c.box_x_min    = 0;
    c.box_x_max    = 32'sh1000_0000;
    c.box_y_min    = 0;
    c.box_y_max    = 32'sh1000_0000;
    c.scale_x      = ONE;
    c.scale_y      = ONE;
    c.image_width  = DIM_W'(MAX_DIM);
    c.image_height = DIM_W'(MAX_DIM);
    load_cfg(c);
    send(mk(OP_CROSS, 2048 * ONE + ONE / 2, 100 * ONE + ONE / 4, 8'hFF, 8'hFF, 8'hFF));
    send(mk(OP_CROSS, 32'sh1000_0000, 32'sh1000_0000, 8'h00, 8'h00, 8'h00));
    send(mk(OP_CROSS, 3 * ONE, 4093 * ONE, 8'h80, 8'h01, 8'h7F));
    send(mk(OP_BODY, 32'sh0FFF_FFFF, 0, 8'h00, 8'hFF, 8'h00));
    drain();

    // 1x1 image: a cross shrinks to its center, once per arm.
    c.box_x_min    = -ONE;
    c.box_x_max    = ONE;
    c.box_y_min    = -ONE;
    c.box_y_max    = ONE;
    c.image_width  = DIM_W'(1);
    c.image_height = DIM_W'(1);
    load_cfg(c);
    send(mk(OP_CROSS, 0, 0, 8'h11, 8'h22, 8'h33));
    send(mk(OP_BODY, ONE, -ONE, 8'h00, 8'h00, 8'h00));
    drain();

    // Inverted x range: nothing is inside, nothing comes out.
    c.box_x_min    = ONE;
    c.box_x_max    = 0;
    c.box_y_min    = 0;
    c.box_y_max    = ONE;
    c.image_width  = DIM_W'(1024);
    c.image_height = DIM_W'(1024);
    load_cfg(c);
    send(mk(OP_CROSS, 0, 0, 8'hFF, 8'hFF, 8'hFF));
    send(mk(OP_BODY, ONE, ONE, 8'hFF, 8'hFF, 8'hFF));
    send(mk(OP_CROSS, ONE / 2, ONE / 2, 8'hFF, 8'hFF, 8'hFF));
    drain();

    // Random phases, each under a fresh config.
    for (int ph = 0; ph < RAND_PHASE; ph++) begin
      load_cfg(rand_cfg());
      for (int k = 0; k < PHASE_LEN; k++) send(rand_item());
      drain();
    end

    if (sb.errors == 0) begin
      $display("world_to_pixel_cross_marker_core_tb: done, clean");
    end else begin
      $display("world_to_pixel_cross_marker_core_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/wpcm_pkg.sv
hdl/wpcm_front.sv
hdl/wpcm_queue.sv
hdl/wpcm_back.sv
hdl/world_to_pixel_cross_marker_core.sv
hdl/wpcm_checker.sv
tb/world_to_pixel_cross_marker_core_tb.sv
